// ===== rtl/rbsi_pkg.sv =====
// Shared types and register codes for the ray versus box slab intersect block.
package rbsi_pkg;

  // Configuration register codes, in address order
  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned NUM_DIVS  = 6;

endpackage

// ===== rtl/ray_box_slab_intersect.sv =====
// Ray versus axis-aligned box test, slab method, fully pipelined.
//
// One ray (origin and direction, signed Q16.16) enters per cycle and is tested
// against the box held in six configuration registers. For each axis the entry
// and exit parameters (bound - origin) / direction are computed by six restoring
// dividers that are unrolled into COORD_WIDTH+16 register stages, one quotient
// bit per stage; the quotients are then saturated to the signed COORD_WIDTH
// range, combined as the largest entry and the smallest exit, and compared.
// Throughput is one ray per cycle while the output does not stall; each ray
// passes the input register, the divider stages, the saturate, combine and
// output registers. An axis whose direction is zero passes only when the origin
// lies inside that slab and adds no bound. On a miss t_near and t_far are zero;
// a hit with all axes parallel reports the full signed range. The whole pipe
// holds while a result waits on out_tready and the output register is full.
// Configuration: APB writes at byte address 4*i (8*i when COORD_WIDTH > 32);
// the box is sampled as each ray enters, so write it only while no ray is in
// flight.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  // fields from bit 0: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  // fields from bit 0: hit, t_near, t_far
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0]   out_tdata,
  // configuration port
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0] cfg_paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] cfg_pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int W      = COORD_WIDTH;
  localparam int L      = COORD_WIDTH + rbsi_pkg::FRAC_BITS;   // quotient bits
  localparam int ND     = rbsi_pkg::NUM_DIVS;
  localparam int NA     = rbsi_pkg::NUM_AXES;
  localparam int DATA_W = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int ADDR_W = (COORD_WIDTH > 32) ? 6 : 5;
  localparam int ASH    = (COORD_WIDTH > 32) ? 3 : 2;
  localparam int OUT_W  = ((2*COORD_WIDTH+1+7)/8)*8;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [L-1:0] QPOS = {{(L-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [L-1:0] QNEG = QPOS + L'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [W-1:0] box_lo_r [NA];
  logic [W-1:0] box_hi_r [NA];
  rbsi_pkg::reg_idx_t cfg_idx;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = rbsi_pkg::reg_idx_t'(cfg_paddr[ADDR_W-1:ASH]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        rbsi_pkg::REG_MIN_X: box_lo_r[0] <= cfg_pwdata[W-1:0];
        rbsi_pkg::REG_MIN_Y: box_lo_r[1] <= cfg_pwdata[W-1:0];
        rbsi_pkg::REG_MIN_Z: box_lo_r[2] <= cfg_pwdata[W-1:0];
        rbsi_pkg::REG_MAX_X: box_hi_r[0] <= cfg_pwdata[W-1:0];
        rbsi_pkg::REG_MAX_Y: box_hi_r[1] <= cfg_pwdata[W-1:0];
        rbsi_pkg::REG_MAX_Z: box_hi_r[2] <= cfg_pwdata[W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rbsi_pkg::REG_MIN_X: cfg_prdata = DATA_W'(box_lo_r[0]);
      rbsi_pkg::REG_MIN_Y: cfg_prdata = DATA_W'(box_lo_r[1]);
      rbsi_pkg::REG_MIN_Z: cfg_prdata = DATA_W'(box_lo_r[2]);
      rbsi_pkg::REG_MAX_X: cfg_prdata = DATA_W'(box_hi_r[0]);
      rbsi_pkg::REG_MAX_Y: cfg_prdata = DATA_W'(box_hi_r[1]);
      rbsi_pkg::REG_MAX_Z: cfg_prdata = DATA_W'(box_hi_r[2]);
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: advance everything unless a result waits at the output
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_r;
  assign en        = out_tready || !out_valid_r;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Input stage: slab numerators, divisor magnitudes, parallel axis check
  // Divider j: 2*a is the entry of axis a, 2*a+1 its exit.
  // ---------------------------------------------------------------------------
  logic [W-1:0] num_r [L+1][ND];
  logic [W-1:0] den_r [L+1][ND];
  logic         neg_r [L+1][ND];
  logic [W-1:0] rem_r [L+1][ND];
  logic [L-1:0] quo_r [L+1][ND];
  logic [NA-1:0] par_r [L+1];
  logic         okp_r [L+1];
  logic         vld_r [L+1];

  logic [W-1:0]  num_nxt [ND];
  logic [W-1:0]  den_nxt [ND];
  logic          neg_nxt [ND];
  logic [NA-1:0] par_nxt;
  logic          okp_nxt;

  always_comb begin
    logic signed [W-1:0] org, dir, lo, hi, bnd;
    logic signed [W:0]   diff;
    logic [W:0]          dmag;
    okp_nxt = 1'b1;
    for (int a = 0; a < NA; a++) begin
      org = $signed(in_tdata[a*W +: W]);
      dir = $signed(in_tdata[(a+NA)*W +: W]);
      lo  = $signed(box_lo_r[a]);
      hi  = $signed(box_hi_r[a]);
      par_nxt[a] = (dir == '0);
      if (par_nxt[a] && (org < lo || org > hi)) okp_nxt = 1'b0;
      dmag = dir[W-1] ? -{dir[W-1], dir} : {1'b0, dir};
      for (int k = 0; k < 2; k++) begin
        // entry takes the lower bound for a positive direction
        bnd = ((k == 0) != dir[W-1]) ? lo : hi;
        diff = {bnd[W-1], bnd} - {org[W-1], org};
        // the magnitude of a difference of two W-bit values always fits in W bits
        num_nxt[2*a+k] = diff[W] ? W'(-diff) : diff[W-1:0];
        den_nxt[2*a+k] = dmag[W-1:0];
        neg_nxt[2*a+k] = diff[W] ^ dir[W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ND; j++) begin
        num_r[0][j] <= num_nxt[j];
        den_r[0][j] <= den_nxt[j];
        neg_r[0][j] <= neg_nxt[j];
        rem_r[0][j] <= '0;
        quo_r[0][j] <= '0;
      end
      par_r[0] <= par_nxt;
      okp_r[0] <= okp_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: one restoring step per stage, one quotient bit each
  // ---------------------------------------------------------------------------
  for (genvar s = 0; s < L; s++) begin : g_stage
    for (genvar j = 0; j < ND; j++) begin : g_div
      logic       nbit;
      logic [W:0] sh;
      logic [W:0] dif;
      logic       ge;

      if (s < W) begin : g_bit
        assign nbit = num_r[s][j][W-1-s];
      end else begin : g_zero
        assign nbit = 1'b0;
      end

      assign sh  = {rem_r[s][j], nbit};
      assign ge  = (sh >= {1'b0, den_r[s][j]});
      assign dif = sh - {1'b0, den_r[s][j]};

      always_ff @(posedge clk) begin
        if (en) begin
          num_r[s+1][j] <= num_r[s][j];
          den_r[s+1][j] <= den_r[s][j];
          neg_r[s+1][j] <= neg_r[s][j];
          rem_r[s+1][j] <= ge ? dif[W-1:0] : sh[W-1:0];
          quo_r[s+1][j] <= {quo_r[s][j][L-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        par_r[s+1] <= par_r[s];
        okp_r[s+1] <= okp_r[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Saturate stage: clamp quotients to the signed range and apply the sign
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] t_r [ND];
  logic signed [W-1:0] t_nxt [ND];
  logic [NA-1:0]       sat_par_r;
  logic                sat_okp_r;
  logic                sat_vld_r;

  always_comb begin
    logic [L-1:0] q;
    for (int j = 0; j < ND; j++) begin
      q = quo_r[L][j];
      if (neg_r[L][j]) begin
        t_nxt[j] = (q > QNEG) ? SMIN : -$signed(q[W-1:0]);
      end else begin
        t_nxt[j] = (q > QPOS) ? SMAX : $signed(q[W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_vld_r <= 1'b0;
    end else if (en) begin
      sat_vld_r <= vld_r[L];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ND; j++) t_r[j] <= t_nxt[j];
      sat_par_r <= par_r[L];
      sat_okp_r <= okp_r[L];
    end
  end

  // ---------------------------------------------------------------------------
  // Combine stage: largest entry, smallest exit over the non-parallel axes
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] tn_r, tf_r, tn_nxt, tf_nxt;
  logic                cmb_okp_r;
  logic                cmb_vld_r;

  always_comb begin
    tn_nxt = SMIN;
    tf_nxt = SMAX;
    for (int a = 0; a < NA; a++) begin
      if (!sat_par_r[a] && t_r[2*a] > tn_nxt)   tn_nxt = t_r[2*a];
      if (!sat_par_r[a] && t_r[2*a+1] < tf_nxt) tf_nxt = t_r[2*a+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmb_vld_r <= 1'b0;
    end else if (en) begin
      cmb_vld_r <= sat_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn_r      <= tn_nxt;
      tf_r      <= tf_nxt;
      cmb_okp_r <= sat_okp_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: final hit test, zero the parameters on a miss
  // ---------------------------------------------------------------------------
  logic                hit_nxt;
  logic                out_hit_r;
  logic signed [W-1:0] out_tn_r, out_tf_r;

  assign hit_nxt = cmb_okp_r && (tn_r <= tf_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cmb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= hit_nxt;
      out_tn_r  <= hit_nxt ? tn_r : '0;
      out_tf_r  <= hit_nxt ? tf_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_tf_r, out_tn_r, out_hit_r});

endmodule

// ===== rtl/rbsi_checker.sv =====
// Port-level checks for the ray versus box slab intersect block, with its bind.
module rbsi_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] out_tdata
);

  localparam int W = COORD_WIDTH;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty output register never blocks a new request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a waiting result stalls the input
  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result waits");

  // a miss carries zero parameters
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[2*W:1] == '0)
    else $error("miss with nonzero parameters");

  // a hit has entry not beyond exit
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      $signed(out_tdata[W:1]) <= $signed(out_tdata[2*W:W+1]))
    else $error("hit with t_near above t_far");

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
